### hw/rtl/g2rw_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// g2rw_pkg
// Shared types, constants and font contents for the glyph window stream.
// ----------------------------------------------------------------------------
package g2rw_pkg;

  localparam int CoordW   = 10;
  localparam int ColorW   = 16;
  localparam int CodeW    = 8;
  localparam int GlyphW   = 40;   // five column bytes, column 0 in the top byte
  localparam int GlyphCnt = 95;
  localparam int GlyphAw  = 7;
  localparam int ChunkW   = 6;    // 40 results per character
  localparam int LineW    = 4;    // 14 scaled lines
  localparam int ColW     = 4;    // 10 scaled columns

  // Display controller commands
  localparam logic [7:0] CMD_COL_ADDR = 8'h2A;
  localparam logic [7:0] CMD_ROW_ADDR = 8'h2B;
  localparam logic [7:0] CMD_MEM_WR   = 8'h2C;

  // Printable range and substitute glyph
  localparam logic [CodeW-1:0] CODE_FIRST = 8'h20;
  localparam logic [CodeW-1:0] CODE_LAST  = 8'h7E;
  localparam logic [CodeW-1:0] CODE_SUBST = 8'h3F;

  // Register indexes
  localparam logic [0:0] REG_COL_OFFSET = 1'b0;
  localparam logic [0:0] REG_ROW_OFFSET = 1'b1;

  localparam logic [CoordW-1:0] COL_OFFSET_RST = 10'd52;
  localparam logic [CoordW-1:0] ROW_OFFSET_RST = 10'd40;

  // Cell geometry added to the window origin
  localparam logic [15:0] CELL_W_M1 = 16'd9;
  localparam logic [15:0] CELL_H_M1 = 16'd13;
  localparam logic [ColW-1:0] CELL_COLS = 4'd10;

  // Result slots within one character
  localparam logic [ChunkW-1:0] SLOT_COL_CMD  = 6'd0;
  localparam logic [ChunkW-1:0] SLOT_COL_DATA = 6'd1;
  localparam logic [ChunkW-1:0] SLOT_ROW_CMD  = 6'd2;
  localparam logic [ChunkW-1:0] SLOT_ROW_DATA = 6'd3;
  localparam logic [ChunkW-1:0] SLOT_WR_CMD   = 6'd4;
  localparam logic [ChunkW-1:0] SLOT_LAST     = 6'd39;

  localparam logic [3:0] BYTES_CMD  = 4'd1;
  localparam logic [3:0] BYTES_ADDR = 4'd4;
  localparam logic [3:0] BYTES_PIX  = 4'd8;

  typedef struct packed {
    logic [ColorW-1:0] bg_color;
    logic [ColorW-1:0] fg_color;
    logic [CoordW-1:0] pos_y;
    logic [CoordW-1:0] pos_x;
    logic [CodeW-1:0]  char_code;
  } item_t;

  typedef struct packed {
    logic               en;
    logic [GlyphAw-1:0] addr;
  } rom_req_t;

  // 5x7 font, one row per glyph from 0x20, column 0 in bits 39:32
  localparam logic [GlyphW-1:0] FONT_ROWS [GlyphCnt] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h1008081008
  };

endpackage : g2rw_pkg
`default_nettype wire

### hw/rtl/g2rw_font_rom.sv
`default_nettype none
// ----------------------------------------------------------------------------
// g2rw_font_rom
// Synchronous font ROM: one whole glyph (five column bytes) per read,
// data valid in the cycle after the read strobe and held until the next read.
// ----------------------------------------------------------------------------
module g2rw_font_rom (
  input  wire logic                      clk,
  input  wire g2rw_pkg::rom_req_t        req,
  output logic [g2rw_pkg::GlyphW-1:0]    rd_data_r
);
  import g2rw_pkg::*;

  // Register the selected glyph row
  always_ff @(posedge clk) begin
    if (req.en) begin
      rd_data_r <= FONT_ROWS[req.addr];
    end
  end

endmodule : g2rw_font_rom
`default_nettype wire

### hw/rtl/g2rw_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// g2rw_seq
// Result sequencer: walks the 40 result slots of one character, builds the
// window commands and the scaled pixel chunks, and holds the output register.
// ----------------------------------------------------------------------------
module g2rw_seq (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  // Character from the input buffer
  input  wire logic                        item_valid,
  input  wire g2rw_pkg::item_t             item,
  output logic                             item_take,
  // Offsets
  input  wire logic [g2rw_pkg::CoordW-1:0] col_offset,
  input  wire logic [g2rw_pkg::CoordW-1:0] row_offset,
  // Font ROM
  output g2rw_pkg::rom_req_t               rom_req,
  input  wire logic [g2rw_pkg::GlyphW-1:0] rom_data,
  // Result register
  output logic                             out_valid_r,
  input  wire logic                        out_ready,
  output logic                             out_is_data_r,
  output logic [3:0]                       out_count_r,
  output logic [63:0]                      out_payload_r,
  output logic                             out_last_r
);
  import g2rw_pkg::*;

  logic                busy_r;
  logic [ChunkW-1:0]   slot_r, slot_nxt;
  logic [LineW-1:0]    line_r, line_nxt;
  logic [ColW-1:0]     col_r, col_nxt;
  logic [CoordW-1:0]   x_r, y_r;
  logic [ColorW-1:0]   fg_r, bg_r;

  logic                advance;
  logic                load;
  logic                is_data;
  logic [3:0]          count;
  logic [63:0]         payload;
  logic [15:0]         col_lo, col_hi, row_lo, row_hi;
  logic [63:0]         pix_word;
  logic [ColW:0]       col_sum;
  logic [CodeW-1:0]    code_fix;

  // Pick one glyph column byte, column 0 at the top of the row
  function automatic logic [7:0] glyph_col(input logic [GlyphW-1:0] g,
                                           input logic [2:0] k);
    logic [7:0] b;
    case (k)
      3'd0:    b = g[39:32];
      3'd1:    b = g[31:24];
      3'd2:    b = g[23:16];
      3'd3:    b = g[15:8];
      default: b = g[7:0];
    endcase
    return b;
  endfunction

  assign advance   = busy_r && (!out_valid_r || out_ready);
  assign load      = item_valid && (!busy_r || (advance && slot_r == SLOT_LAST));
  assign item_take = load;

  // Map unprintable codes to the substitute glyph
  assign code_fix = (item.char_code < CODE_FIRST || item.char_code > CODE_LAST) ?
                    CODE_SUBST : item.char_code;
  assign rom_req.en   = load;
  assign rom_req.addr = GlyphAw'(code_fix - CODE_FIRST);

  // Window coordinates, 16-bit wrapping sums
  assign col_lo = 16'(x_r) + 16'(col_offset);
  assign col_hi = col_lo + CELL_W_M1;
  assign row_lo = 16'(y_r) + 16'(row_offset);
  assign row_hi = row_lo + CELL_H_M1;

  // Four scaled pixels starting at (line_r, col_r)
  always_comb begin
    logic [ColW:0]    c;
    logic [LineW-1:0] l;
    logic [7:0]       colbyte;
    pix_word = '0;
    for (int j = 0; j < 4; j++) begin
      c = 5'(col_r) + 5'(j);
      l = line_r;
      if (c >= 5'(CELL_COLS)) begin
        c = c - 5'(CELL_COLS);
        l = l + 4'd1;
      end
      colbyte = glyph_col(rom_data, c[3:1]);
      pix_word[63-16*j -: 16] = colbyte[l[3:1]] ? fg_r : bg_r;
    end
  end

  // Decode the current slot
  always_comb begin
    unique case (slot_r)
      SLOT_COL_CMD: begin
        is_data = 1'b0; count = BYTES_CMD;  payload = {CMD_COL_ADDR, 56'd0};
      end
      SLOT_COL_DATA: begin
        is_data = 1'b1; count = BYTES_ADDR; payload = {col_lo, col_hi, 32'd0};
      end
      SLOT_ROW_CMD: begin
        is_data = 1'b0; count = BYTES_CMD;  payload = {CMD_ROW_ADDR, 56'd0};
      end
      SLOT_ROW_DATA: begin
        is_data = 1'b1; count = BYTES_ADDR; payload = {row_lo, row_hi, 32'd0};
      end
      SLOT_WR_CMD: begin
        is_data = 1'b0; count = BYTES_CMD;  payload = {CMD_MEM_WR, 56'd0};
      end
      default: begin
        is_data = 1'b1; count = BYTES_PIX;  payload = pix_word;
      end
    endcase
  end

  // Step the pixel position by four after each pixel chunk
  assign col_sum = 5'(col_r) + 5'd4;
  always_comb begin
    slot_nxt = slot_r + 6'd1;
    line_nxt = line_r;
    col_nxt  = col_r;
    if (slot_r > SLOT_WR_CMD) begin
      if (col_sum >= 5'(CELL_COLS)) begin
        col_nxt  = ColW'(col_sum - 5'(CELL_COLS));
        line_nxt = line_r + 4'd1;
      end else begin
        col_nxt  = col_sum[ColW-1:0];
      end
    end
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      slot_r <= '0;
      line_r <= '0;
      col_r  <= '0;
    end else if (load) begin
      busy_r <= 1'b1;
      slot_r <= '0;
      line_r <= '0;
      col_r  <= '0;
    end else if (advance) begin
      busy_r <= (slot_r != SLOT_LAST);
      slot_r <= slot_nxt;
      line_r <= line_nxt;
      col_r  <= col_nxt;
    end
  end

  // Hold the character fields while it streams
  always_ff @(posedge clk) begin
    if (load) begin
      x_r  <= item.pos_x;
      y_r  <= item.pos_y;
      fg_r <= item.fg_color;
      bg_r <= item.bg_color;
    end
  end

  // Output register: load on advance, drop after the transfer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_is_data_r <= is_data;
      out_count_r   <= count;
      out_payload_r <= payload;
      out_last_r    <= (slot_r == SLOT_LAST);
    end
  end

endmodule : g2rw_seq
`default_nettype wire

### hw/rtl/glyph_to_rgb565_window_stream.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_to_rgb565_window_stream
// 5x7 character generator producing a display window and pixel stream.
// ----------------------------------------------------------------------------
// Each input transfer is one character; the block answers with 40 output
// transfers: column-address command and its four bytes, row-address command
// and its four bytes, memory-write command, then 35 chunks of eight pixel
// bytes (10x14 cell, font scaled 2x, RGB565 high byte first), the last chunk
// flagged by tlast. One output transfer leaves per cycle while out_tready
// holds no stall; the first result is registered in the input buffer, then
// in the sequencer state, then in the output register. A one-entry input
// buffer takes the next character while the current one still streams. The
// glyph comes from a synchronous font ROM read once per character. Offsets
// may only change while idle.
// ----------------------------------------------------------------------------
module glyph_to_rgb565_window_stream (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input: char_code[7:0], pos_x[17:8], pos_y[27:18], fg_color[43:28],
  //        bg_color[59:44], zero fill [63:60]
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,
  // Output: byte_count[3:0], payload[67:4], zero fill [71:68]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [71:0]      out_tdata,
  output logic             out_tuser,   // is_data[0]
  output logic             out_tlast,
  // Configuration
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_addr,
  input  wire logic [9:0]  cfg_wdata
);
  import g2rw_pkg::*;

  logic              buf_valid_r;
  item_t             buf_item_r;
  logic              item_take;
  logic [CoordW-1:0] col_offset_r, row_offset_r;
  rom_req_t          rom_req;
  logic [GlyphW-1:0] rom_data;
  logic [3:0]        out_count;
  logic [63:0]       out_payload;

  // Offset registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_offset_r <= COL_OFFSET_RST;
      row_offset_r <= ROW_OFFSET_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_COL_OFFSET: col_offset_r <= cfg_wdata;
        REG_ROW_OFFSET: row_offset_r <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  // One-entry input buffer
  assign in_tready = !buf_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      buf_valid_r <= 1'b1;
    end else if (item_take) begin
      buf_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      buf_item_r <= in_tdata[$bits(item_t)-1:0];
    end
  end

  g2rw_font_rom u_rom (
    .clk       (clk),
    .req       (rom_req),
    .rd_data_r (rom_data)
  );

  g2rw_seq u_seq (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (buf_valid_r),
    .item          (buf_item_r),
    .item_take     (item_take),
    .col_offset    (col_offset_r),
    .row_offset    (row_offset_r),
    .rom_req       (rom_req),
    .rom_data      (rom_data),
    .out_valid_r   (out_tvalid),
    .out_ready     (out_tready),
    .out_is_data_r (out_tuser),
    .out_count_r   (out_count),
    .out_payload_r (out_payload),
    .out_last_r    (out_tlast)
  );

  assign out_tdata = {4'd0, out_payload, out_count};

endmodule : glyph_to_rgb565_window_stream
`default_nettype wire

### hw/rtl/g2rw_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// g2rw_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module g2rw_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [71:0] out_tdata,
  input  wire logic        out_tuser,
  input  wire logic        out_tlast
);

  // Stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("result changed while stalled");

  // Final chunk is a full pixel chunk
  a_last_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast |-> out_tuser && out_tdata[3:0] == 4'd8)
    else $error("last chunk is not eight data bytes");

  // Commands carry one byte and nothing else
  a_cmd_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[3:0] == 4'd1 && out_tdata[59:4] == 56'd0
      && !out_tlast)
    else $error("malformed command transfer");

  // Short data transfers leave low bytes clear
  a_addr_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser && out_tdata[3:0] == 4'd4 |-> out_tdata[35:4] == 32'd0)
    else $error("address data has stray low bytes");

endmodule : g2rw_checker

bind glyph_to_rgb565_window_stream g2rw_checker u_g2rw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
`default_nettype wire

### verif/tb_glyph_to_rgb565_window_stream.sv
// ----------------------------------------------------------------------------
// tb_glyph_to_rgb565_window_stream
// Self-checking bench for the 5x7 character window stream generator.
// ----------------------------------------------------------------------------
// Characters go in as stream transfers. A scoreboard class renders each
// accepted character on its own, using a private copy of the font and the
// window offsets, into the 40 expected output chunks. It then compares every
// output transfer field by field against the oldest pending chunk. Directed
// characters cover the printable range ends, unprintable codes and color
// extremes. Random phases follow, each with its own offset setting and its
// own mix of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_glyph_to_rgb565_window_stream;
  timeunit 1ns;
  timeprecision 1ps;

  import g2rw_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_CHARS = 55;

  // Expected display commands and character range
  localparam logic [7:0] CASET     = 8'h2A;
  localparam logic [7:0] RASET     = 8'h2B;
  localparam logic [7:0] RAMWR     = 8'h2C;
  localparam logic [7:0] PRINT_LO  = 8'h20;
  localparam logic [7:0] PRINT_HI  = 8'h7E;
  localparam logic [7:0] QMARK     = 8'h3F;
  localparam logic [3:0] N_CMD     = 4'd1;
  localparam logic [3:0] N_ADDR    = 4'd4;
  localparam logic [3:0] N_PIX     = 4'd8;
  localparam logic [9:0] COL_RESET = 10'd52;
  localparam logic [9:0] ROW_RESET = 10'd40;

  // Font, one entry per code from 0x20, column 0 in the top byte
  localparam logic [39:0] FONT5X7 [95] = '{
    40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
    40'h2313086462, 40'h3649552250, 40'h0005030000, 40'h001C224100, 40'h0041221C00,
    40'h14083E0814, 40'h08083E0808, 40'h0050300000, 40'h0808080808, 40'h0060600000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h0204081020, 40'h0041417F00, 40'h0402010204, 40'h4040404040, 40'h0001020400,
    40'h2054545478, 40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418,
    40'h087E090102, 40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00,
    40'h7F10284400, 40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'h7C14141408, 40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020,
    40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C,
    40'h4464544C44, 40'h0008364100, 40'h00007F0000, 40'h0041360800, 40'h1008081008
  };

  typedef struct packed {
    logic        is_data;
    logic [3:0]  nbytes;
    logic [63:0] payload;
    logic        last;
  } chunk_t;

  // --------------------------------------------------------------------------
  // Scoreboard: renders characters into chunks and matches output transfers
  // --------------------------------------------------------------------------
  class cell_stream_board;
    chunk_t     chunk_q[$];
    logic [9:0] col_off = COL_RESET;
    logic [9:0] row_off = ROW_RESET;
    int         errors  = 0;
    int         chars   = 0;
    int         odd_chars = 0;
    int         checked = 0;

    function void set_offsets(logic [9:0] c, logic [9:0] r);
      col_off = c;
      row_off = r;
    endfunction

    function void add_chunk(logic d, logic [3:0] n, logic [63:0] p, logic l);
      chunk_t ck;
      ck.is_data = d;
      ck.nbytes  = n;
      ck.payload = p;
      ck.last    = l;
      chunk_q.push_back(ck);
    endfunction

    // Render one accepted character into its 40 expected chunks
    function void take_char(item_t it);
      logic [7:0]  code;
      logic [39:0] glyph;
      logic [7:0]  colbyte;
      logic [15:0] px;
      logic [15:0] x0, x1, y0, y1;
      logic [63:0] v;
      int          b, p, line, col;

      code = it.char_code;
      if (code < PRINT_LO || code > PRINT_HI) begin
        code = QMARK;
        odd_chars++;
      end
      chars++;
      glyph = FONT5X7[code - PRINT_LO];
      x0 = 16'(it.pos_x) + 16'(col_off);
      x1 = x0 + 16'd9;
      y0 = 16'(it.pos_y) + 16'(row_off);
      y1 = y0 + 16'd13;

      add_chunk(1'b0, N_CMD, {CASET, 56'h0}, 1'b0);
      add_chunk(1'b1, N_ADDR, {x0, x1, 32'h0}, 1'b0);
      add_chunk(1'b0, N_CMD, {RASET, 56'h0}, 1'b0);
      add_chunk(1'b1, N_ADDR, {y0, y1, 32'h0}, 1'b0);
      add_chunk(1'b0, N_CMD, {RAMWR, 56'h0}, 1'b0);

      // Pixels: 2x scaled, row-major, high byte of each pixel first
      for (int c = 0; c < 35; c++) begin
        v = '0;
        for (int i = 0; i < 8; i++) begin
          b       = c * 8 + i;
          p       = b >> 1;
          line    = p / 10;
          col     = p % 10;
          colbyte = 8'(glyph >> (8 * (4 - (col >> 1))));
          px      = colbyte[line >> 1] ? it.fg_color : it.bg_color;
          v       = {v[55:0], (b % 2 == 1) ? px[7:0] : px[15:8]};
        end
        add_chunk(1'b1, N_PIX, v, c == 34);
      end
    endfunction

    // Compare one output transfer against the oldest pending chunk
    function void match_chunk(chunk_t got);
      chunk_t exp_ck;
      if (chunk_q.size() == 0) begin
        $error("output transfer with nothing pending: payload %h", got.payload);
        errors++;
        return;
      end
      exp_ck = chunk_q.pop_front();
      checked++;
      if (got.is_data !== exp_ck.is_data) begin
        $error("is_data: expected %0d, got %0d", exp_ck.is_data, got.is_data);
        errors++;
      end
      if (got.nbytes !== exp_ck.nbytes) begin
        $error("byte_count: expected %0d, got %0d", exp_ck.nbytes, got.nbytes);
        errors++;
      end
      if (got.payload !== exp_ck.payload) begin
        $error("payload: expected %h, got %h", exp_ck.payload, got.payload);
        errors++;
      end
      if (got.last !== exp_ck.last) begin
        $error("last: expected %0d, got %0d", exp_ck.last, got.last);
        errors++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [71:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;
  logic        cfg_we     = 1'b0;
  logic [0:0]  cfg_addr   = '0;
  logic [9:0]  cfg_wdata  = '0;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int cycles         = 0;

  cell_stream_board board = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  glyph_to_rgb565_window_stream uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Stall the receiver at random
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Note accepted characters first, then check output transfers
  always @(posedge clk) begin
    chunk_t got;
    if (rst_n) begin
      if (in_tvalid && in_tready) board.take_char(item_t'(in_tdata[59:0]));
      if (out_tvalid && out_tready) begin
        got.is_data = out_tuser;
        got.nbytes  = out_tdata[3:0];
        got.payload = out_tdata[67:4];
        got.last    = out_tlast;
        board.match_chunk(got);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  function automatic item_t mk(logic [7:0] code, logic [9:0] x, logic [9:0] y,
                               logic [15:0] fg, logic [15:0] bg);
    item_t it;
    it.char_code = code;
    it.pos_x     = x;
    it.pos_y     = y;
    it.fg_color  = fg;
    it.bg_color  = bg;
    return it;
  endfunction

  // Coordinates lean toward the range ends
  function automatic logic [9:0] pick_coord();
    int r;
    r = $urandom_range(9);
    if (r == 0) return 10'd0;
    if (r == 1) return 10'd1023;
    return 10'($urandom_range(1023));
  endfunction

  // Mostly printable codes, the rest any byte
  function automatic item_t rand_char();
    logic [7:0] code;
    if ($urandom_range(99) < 80) code = 8'($urandom_range(PRINT_HI, PRINT_LO));
    else code = 8'($urandom_range(255));
    return mk(code, pick_coord(), pick_coord(), 16'($urandom), 16'($urandom));
  endfunction

  // Offer one character; hold tvalid high across back-to-back transfers
  task automatic send_char(input item_t it);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, it};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop tvalid and hold until every pending chunk has arrived
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.chunk_q.size() != 0) @(posedge clk);
  endtask

  // Write the column offset, then the row offset, while idle
  task automatic write_offsets(input logic [9:0] c, input logic [9:0] r);
    repeat (2) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_COL_OFFSET;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_addr  <= REG_ROW_OFFSET;
    cfg_wdata <= r;
    @(posedge clk);
    cfg_we    <= 1'b0;
    board.set_offsets(c, r);
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [9:0] col_set [4];
    logic [9:0] row_set [4];
    int         idle_set [4];
    int         stall_set [4];

    col_set   = '{10'd0, 10'd1023, 10'($urandom_range(1023)), 10'd1023};
    row_set   = '{10'd0, 10'd1023, 10'($urandom_range(1023)), 10'd0};
    idle_set  = '{0, 45, 0, 11};
    stall_set = '{0, 0, 45, 11};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: range ends, unprintable codes, color and position extremes
    send_char(mk(PRINT_LO, 10'd0,    10'd0,    16'hFFFF, 16'h0000));
    send_char(mk(PRINT_HI, 10'd1023, 10'd1023, 16'h0000, 16'hFFFF));
    send_char(mk(8'h41,    10'd0,    10'd1023, 16'hF800, 16'h001F));
    send_char(mk(8'h30,    10'd1023, 10'd0,    16'h07E0, 16'hFFFF));
    send_char(mk(QMARK,    10'd512,  10'd256,  16'hAAAA, 16'h5555));
    send_char(mk(8'h00,    10'd1,    10'd1,    16'h5555, 16'hAAAA));
    send_char(mk(8'h1F,    10'd341,  10'd682,  16'h1234, 16'hFEDC));
    send_char(mk(8'h7F,    10'd682,  10'd341,  16'h8001, 16'h7FFE));
    send_char(mk(8'h80,    10'd2,    10'd1022, 16'h0F0F, 16'hF0F0));
    send_char(mk(8'hFF,    10'd1023, 10'd1023, 16'hFFFF, 16'hFFFF));
    send_char(mk(8'h23,    10'd100,  10'd200,  16'h0000, 16'h0000));
    send_char(mk(8'h57,    10'd300,  10'd400,  16'hFFE0, 16'h0010));
    send_char(mk(8'h67,    10'd500,  10'd600,  16'h001F, 16'hF81F));
    send_char(mk(8'h7C,    10'd700,  10'd800,  16'hC618, 16'h39E7));
    drain();

    // Random phases, each with its own offsets and flow-control mix
    for (int ph = 0; ph < 4; ph++) begin
      write_offsets(col_set[ph], row_set[ph]);
      send_idle_pct  = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      for (int n = 0; n < PHASE_CHARS; n++) send_char(rand_char());
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Rendered %0d characters (%0d substituted) under five offset settings",
             board.chars, board.odd_chars);
    $display("and four sender/receiver idling mixes; %0d output chunks compared.",
             board.checked);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule : tb_glyph_to_rgb565_window_stream

### glyph_to_rgb565_window_stream.f
hw/rtl/g2rw_pkg.sv
hw/rtl/g2rw_font_rom.sv
hw/rtl/g2rw_seq.sv
hw/rtl/glyph_to_rgb565_window_stream.sv
hw/rtl/g2rw_checker.sv
verif/tb_glyph_to_rgb565_window_stream.sv
